@@ design/btc_pkg.sv @@
// Shared types and constants for the block transposition cipher.
// Controller state, controller/datapath command and status bundles.
// No dependencies.
package btc_pkg;

  // Padding character inserted on flush and removed in decrypt mode
  localparam logic [7:0] PAD_BYTE = 8'h2A;

  // Input item kinds carried on tuser
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_MAP   = 2'd2;

  // Register reset values (identity permutation, 8-byte blocks, encrypt)
  localparam logic [3:0]  BLOCK_SIZE_RST = 4'd8;
  localparam logic [23:0] PERM_MAP_RST   = 24'hFAC688;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       wr_byte;      // store input byte at fill position
    logic       start_full;   // block completed, begin emission with no padding
    logic       start_flush;  // flush, begin emission padding past fill count
    logic       clr_fill;     // drop the pending partial block
    logic       scan_adv;     // consume candidate at current step
    logic       fin;          // move pending byte to output as last of run
    logic [2:0] step;         // output position being scanned
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       fill_zero;
    logic       blk_done;     // the byte on the input completes a block
    logic       decrypt;
    logic [3:0] n_eff;
    logic       keep;         // candidate at current step survives
    logic       pend_valid;
    logic       out_free;
  } status_t;

endpackage

@@ design/block_transposition_cipher.sv @@
// Top level of the block transposition cipher.
// Joins btc_ctrl and btc_dp; depends on btc_pkg.
//
// Usage:
//   in_*  : one item per byte. in_tuser is the opcode (data byte or flush),
//           in_tdata the byte. Bytes gather into a block of block_size.
//   out_* : permuted bytes; out_tlast marks the last byte caused by one
//           input item.
//   cfg_* : register writes (decrypt mode, block size, permutation map),
//           always ready; write only while no run is in progress.
// Sequence:
//   A data byte that does not complete a block is taken without a run. An item
//   that completes a block, or a flush in encrypt mode with bytes pending,
//   starts a run that holds the input through the scan and final states,
//   the controller stepping one output position per cycle unless a stall
//   pauses it; each kept byte passes the pending, then the output register.
// Reset (rst_n, synchronous): identity permutation, 8-byte blocks, encrypt
//   mode, empty block, no output pending.
// Stall: a low out_tready holds a valid output register and pauses the scan
//   at a kept byte that needs it; input stays blocked until the run ends.
module block_transposition_cipher #(
  parameter int MAX_BLOCK = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                   cfg_data
);
  import btc_pkg::*;

  cmd_t    cmd;
  status_t st;

  btc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .st        (st),
    .cmd       (cmd)
  );

  btc_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

@@ design/btc_dp.sv @@
// Datapath of the block transposition cipher: config registers, block
// buffer, fill count, permutation select, pending and output registers.
// Depends on btc_pkg.
module btc_dp #(
  parameter int MAX_BLOCK = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  btc_pkg::cmd_t                   cmd,
  output btc_pkg::status_t                st,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] out_byte
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [23:0]                     cfg_data
);
  import btc_pkg::*;

  localparam int LIM = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
  localparam int IW  = $clog2(LIM);
  localparam logic [3:0] LIM_N = 4'(LIM);

  logic        decrypt_r;
  logic [3:0]  block_size_r;
  logic [23:0] perm_r;
  logic [7:0]  buf_r [LIM];
  logic [3:0]  fill_r, fill_nxt;
  logic [3:0]  bound_r;
  logic [7:0]  pend_byte_r;
  logic        pend_valid_r, pend_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [3:0]    n_eff;
  logic [3:0]    wr_idx;
  logic [2:0]    src;
  logic          is_pad;
  logic [7:0]    cand;
  logic          keep;
  logic          out_free;
  logic          load_mid;

  // Clamp block size to the supported range
  always_comb begin
    if (block_size_r < 4'd2)      n_eff = 4'd2;
    else if (block_size_r > LIM_N) n_eff = LIM_N;
    else                           n_eff = block_size_r;
  end

  // Write position: overwrite last slot when size was lowered mid-block
  assign wr_idx = (fill_r < n_eff) ? fill_r : (n_eff - 4'd1);

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r    <= 1'b0;
      block_size_r <= BLOCK_SIZE_RST;
      perm_r       <= PERM_MAP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DECRYPT:    decrypt_r    <= cfg_data[0];
        REG_BLOCK_SIZE: block_size_r <= cfg_data[3:0];
        REG_PERM_MAP:   perm_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block buffer, written one byte per data item
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) buf_r[wr_idx[IW-1:0]] <= in_tdata;
  end

  // Fill count and padding bound for the run being emitted
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.wr_byte)                                   fill_nxt = wr_idx + 4'd1;
    if (cmd.start_full || cmd.start_flush || cmd.clr_fill) fill_nxt = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= 4'd0;
    else        fill_r <= fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.start_full)       bound_r <= n_eff;
    else if (cmd.start_flush) bound_r <= fill_r;
  end

  // Candidate byte for the current output position
  assign src    = perm_r[3*cmd.step +: 3];
  assign is_pad = ({1'b0, src} >= n_eff) || ({1'b0, src} >= bound_r);
  assign cand   = is_pad ? PAD_BYTE : buf_r[src[IW-1:0]];
  assign keep   = !(decrypt_r && (cand == PAD_BYTE));

  // Hold one kept byte back until we know whether it ends the run
  assign out_free = !out_valid_r || out_tready;
  assign load_mid = cmd.scan_adv && keep && pend_valid_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.scan_adv && keep) pend_valid_nxt = 1'b1;
    if (cmd.fin)              pend_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_adv && keep) pend_byte_r <= cand;
  end

  // Output register
  always_comb begin
    if (load_mid || cmd.fin) out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || cmd.fin) begin
      out_byte_r <= pend_byte_r;
      out_last_r <= cmd.fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  // Status back to the controller
  assign st.fill_zero  = (fill_r == 4'd0);
  assign st.blk_done   = ((wr_idx + 4'd1) == n_eff);
  assign st.decrypt    = decrypt_r;
  assign st.n_eff      = n_eff;
  assign st.keep       = keep;
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free;

  // Checks
  a_fin_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> pend_valid_r) else $error("final emit without pending byte");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load_mid |-> out_free) else $error("output register overwritten");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LIM_N) else $error("fill count beyond block limit");
  a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (!pend_valid_r && out_valid_r && out_last_r))
    else $error("final byte not moved to output");

endmodule

@@ design/btc_ctrl.sv @@
// Controller of the block transposition cipher: accepts items and steps
// through output positions of a block. Depends on btc_pkg.
module btc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,   // [0] opcode
  input  btc_pkg::status_t  st,
  output btc_pkg::cmd_t     cmd
);
  import btc_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       last_step;

  assign last_step = ({1'b0, step_r} == (st.n_eff - 4'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == OP_DATA) begin
            cmd.wr_byte = 1'b1;
            if (st.blk_done) begin
              cmd.start_full = 1'b1;
              step_nxt       = 3'd0;
              state_nxt      = ST_SCAN;
            end
          end else if (!st.fill_zero) begin
            if (st.decrypt) begin
              cmd.clr_fill = 1'b1;
            end else begin
              cmd.start_flush = 1'b1;
              step_nxt        = 3'd0;
              state_nxt       = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // Advance unless a kept byte must push the pending one out first
        if (!st.keep || !st.pend_valid || st.out_free) begin
          cmd.scan_adv = 1'b1;
          if (last_step) state_nxt = ST_FINAL;
          else           step_nxt  = step_r + 3'd1;
        end
      end
      ST_FINAL: begin
        if (!st.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_adv || cmd.fin) |-> !in_tready) else $error("item taken mid-run");
  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_full || cmd.start_flush) |=> (state_r == ST_SCAN && step_r == 3'd0))
    else $error("run did not start at position zero");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, step_r} < st.n_eff))
    else $error("step past block size");

endmodule
